/* design/wsu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsu_pkg
// shared widths, command and status codes, sequencer states and the
// status struct of the duplicate search unit
// ----------------------------------------------------------------------------
package wsu_pkg;

	localparam int CMD_W  = 3;
	localparam int VAL_W  = 64;
	localparam int CNT_W  = 7;
	localparam int FILL_W = 7;
	localparam int STAT_W = 2;

	// command codes, anything else acts as a query
	localparam logic [CMD_W-1:0] CMD_PUSH    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_UPUSH   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP     = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_ALL = 3'd3;
	localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd4;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_OVER  = 2'd1,
		STAT_UNDER = 2'd2,
		STAT_DUP   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_POP_RD,
		ST_POP_OUT,
		ST_FINAL
	} state_t;

	typedef struct packed {
		logic done;
		logic hit;
	} scan_stat_t;

endpackage

/* design/wsu_cmd_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsu_cmd_if
// command channel: valid/ready handshake with cmd, value and count
// ----------------------------------------------------------------------------
interface wsu_cmd_if;
	logic                        valid;
	logic                        ready;
	logic [wsu_pkg::CMD_W-1:0]   cmd;
	logic [wsu_pkg::VAL_W-1:0]   value;
	logic [wsu_pkg::CNT_W-1:0]   count;

	modport source (output valid, output cmd, output value, output count, input ready);
	modport sink (input valid, input cmd, input value, input count, output ready);
endinterface

/* design/wsu_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsu_rsp_if
// result channel: valid/ready handshake with one result beat
// ----------------------------------------------------------------------------
interface wsu_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [wsu_pkg::VAL_W-1:0]   popped_word;
	logic                        has_word;
	logic                        last;
	logic [wsu_pkg::FILL_W-1:0]  fill;
	logic                        is_empty_flag;
	logic [wsu_pkg::VAL_W-1:0]   top_word;
	logic [wsu_pkg::STAT_W-1:0]  status;

	modport source (output valid, output popped_word, output has_word, output last,
		output fill, output is_empty_flag, output top_word, output status, input ready);
	modport sink (input valid, input popped_word, input has_word, input last,
		input fill, input is_empty_flag, input top_word, input status, output ready);
endinterface

/* design/wsu_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsu_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module wsu_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* design/wsu_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsu_scan
// duplicate search: walks entries 0..fill-1 through the ram read port,
// one address a cycle, and compares each returned word with the new one
// ----------------------------------------------------------------------------
module wsu_scan #(
	parameter int DEPTH     = 64,
	parameter int WORD_BITS = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [$clog2(DEPTH+1)-1:0]       fill,
	input  logic [WORD_BITS-1:0]             word,
	input  logic [WORD_BITS-1:0]             rd_data,
	output logic                             rd_en,
	output logic [$clog2(DEPTH)-1:0]         rd_addr,
	output wsu_pkg::scan_stat_t              stat
);

	localparam int AW = $clog2(DEPTH);
	localparam int FW = $clog2(DEPTH+1);

	logic          active_q;
	logic [FW-1:0] idx_q;
	logic          pend_s1;
	logic          issue;
	logic          hit;

	assign issue   = active_q && (idx_q < fill);
	assign rd_en   = issue;
	assign rd_addr = idx_q[AW-1:0];

	// compare the word read in the previous cycle
	assign hit       = pend_s1 && (rd_data == word);
	assign stat.hit  = hit;
	assign stat.done = active_q && (hit || (!issue && !pend_s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
			pend_s1  <= 1'b0;
		end else if (start) begin
			active_q <= 1'b1;
			idx_q    <= '0;
			pend_s1  <= 1'b0;
		end else begin
			if (stat.done) begin
				active_q <= 1'b0;
			end
			if (issue) begin
				idx_q <= idx_q + FW'(1);
			end
			pend_s1 <= issue && !stat.done;
		end
	end

endmodule

/* design/word_stack_with_unique_push.sv */
`timescale 1ns / 1ps
// push, pop-all and query give one result beat, registered from the final state after the command beat
// unique push: the search reads one entry a cycle until a hit or the end, then the final state gives the result
// pop-n: per popped word, a ram read of the new top, then the result beat
// one command at a time: req.ready is low until the command's last result is registered
// reset: fill count clears to zero at once; the entry ram is not cleared, no clearing pass
// ----------------------------------------------------------------------------
// word_stack_with_unique_push
// lifo stack of words in a ram, with push, duplicate-checked push, pop-n,
// pop-all and query; every result beat reports fill, empty, top and status
// ----------------------------------------------------------------------------
module word_stack_with_unique_push #(
	parameter int DEPTH     = 64,
	parameter int WORD_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	wsu_cmd_if.sink     req,
	wsu_rsp_if.source   rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int FW = $clog2(DEPTH+1);

	// sequencer and stack state
	wsu_pkg::state_t   state_q, state_d;
	logic [FW-1:0]     fill_q, fill_d;
	logic [FW-1:0]     remain_q, remain_d;
	wsu_pkg::status_t  status_q, status_d;
	logic              wr_pend_q, wr_pend_d;
	logic              clr_pend_q, clr_pend_d;
	logic [WORD_BITS-1:0] word_q, word_d;
	logic [WORD_BITS-1:0] top_q, top_d;

	// output register
	logic                       rsp_valid_q;
	logic [WORD_BITS-1:0]       popped_q;
	logic                       has_word_q;
	logic                       last_q;
	logic [FW-1:0]              fill_out_q;
	logic                       empty_q;
	logic [WORD_BITS-1:0]       top_out_q;
	wsu_pkg::status_t           stat_out_q;

	// beat being loaded into the output register
	logic                  emit;
	logic [WORD_BITS-1:0]  e_word;
	logic                  e_has;
	logic                  e_last;
	logic [FW-1:0]         e_fill;
	logic [WORD_BITS-1:0]  e_top;
	wsu_pkg::status_t      e_stat;

	logic accept;
	logic out_free;
	logic full;

	// ram ports
	logic                 ram_we;
	logic                 ram_re;
	logic [AW-1:0]        ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;
	logic                 pop_re;
	logic [FW-1:0]        fill_m2;
	logic [AW-1:0]        pop_addr;

	// duplicate search unit
	logic                 scan_start;
	logic                 scan_re;
	logic [AW-1:0]        scan_addr;
	wsu_pkg::scan_stat_t  scan_stat;

	assign req.ready = (state_q == wsu_pkg::ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign full      = (fill_q == FW'(DEPTH));

	// new top after a pop sits two below the current fill
	assign fill_m2  = fill_q - FW'(2);
	assign pop_addr = fill_m2[AW-1:0];

	assign ram_re    = scan_re || pop_re;
	assign ram_raddr = pop_re ? pop_addr : scan_addr;

	wsu_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (fill_q[AW-1:0]),
		.wdata (word_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	wsu_scan #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (scan_start),
		.fill    (fill_q),
		.word    (word_q),
		.rd_data (ram_rdata),
		.rd_en   (scan_re),
		.rd_addr (scan_addr),
		.stat    (scan_stat)
	);

	// sequencer: next state, register updates and the result beat
	always_comb begin
		state_d    = state_q;
		fill_d     = fill_q;
		remain_d   = remain_q;
		status_d   = status_q;
		wr_pend_d  = wr_pend_q;
		clr_pend_d = clr_pend_q;
		word_d     = word_q;
		top_d      = top_q;
		emit       = 1'b0;
		e_word     = '0;
		e_has      = 1'b0;
		e_last     = 1'b1;
		e_fill     = fill_q;
		e_top      = top_q;
		e_stat     = status_q;
		scan_start = 1'b0;
		ram_we     = 1'b0;
		pop_re     = 1'b0;
		case (state_q)
			wsu_pkg::ST_IDLE: begin
				if (accept) begin
					word_d     = req.value[WORD_BITS-1:0];
					wr_pend_d  = 1'b0;
					clr_pend_d = 1'b0;
					status_d   = wsu_pkg::STAT_OK;
					state_d    = wsu_pkg::ST_FINAL;
					case (req.cmd)
						wsu_pkg::CMD_PUSH: begin
							if (full) begin
								status_d = wsu_pkg::STAT_OVER;
							end else begin
								wr_pend_d = 1'b1;
							end
						end
						wsu_pkg::CMD_UPUSH: begin
							scan_start = 1'b1;
							state_d    = wsu_pkg::ST_SCAN;
						end
						wsu_pkg::CMD_POP: begin
							// zero count: one beat with no word
							if (req.count == '0) begin
								status_d = wsu_pkg::STAT_OK;
							end else if (fill_q == '0) begin
								status_d = wsu_pkg::STAT_UNDER;
							end else begin
								// count above fill pops everything held
								if (req.count > wsu_pkg::CNT_W'(fill_q)) begin
									remain_d = fill_q;
								end else begin
									remain_d = FW'(req.count);
								end
								state_d = wsu_pkg::ST_POP_RD;
							end
						end
						wsu_pkg::CMD_POP_ALL: begin
							clr_pend_d = 1'b1;
						end
						default: begin
							// query and unused codes change nothing
						end
					endcase
				end
			end
			wsu_pkg::ST_SCAN: begin
				if (scan_stat.done) begin
					state_d = wsu_pkg::ST_FINAL;
					// duplicate wins over a full stack
					if (scan_stat.hit) begin
						status_d = wsu_pkg::STAT_DUP;
					end else if (full) begin
						status_d = wsu_pkg::STAT_OVER;
					end else begin
						wr_pend_d = 1'b1;
					end
				end
			end
			wsu_pkg::ST_POP_RD: begin
				// fetch the entry that becomes top once this word leaves
				pop_re  = (fill_q >= FW'(2));
				state_d = wsu_pkg::ST_POP_OUT;
			end
			wsu_pkg::ST_POP_OUT: begin
				if (out_free) begin
					emit     = 1'b1;
					fill_d   = fill_q - FW'(1);
					top_d    = ram_rdata;
					e_word   = top_q;
					e_has    = 1'b1;
					e_last   = (remain_q == FW'(1));
					e_fill   = fill_d;
					e_top    = ram_rdata;
					e_stat   = wsu_pkg::STAT_OK;
					remain_d = remain_q - FW'(1);
					state_d  = e_last ? wsu_pkg::ST_IDLE : wsu_pkg::ST_POP_RD;
				end
			end
			wsu_pkg::ST_FINAL: begin
				if (out_free) begin
					emit = 1'b1;
					if (wr_pend_q) begin
						ram_we = 1'b1;
						fill_d = fill_q + FW'(1);
						top_d  = word_q;
					end else if (clr_pend_q) begin
						fill_d = '0;
					end
					e_fill  = fill_d;
					e_top   = top_d;
					state_d = wsu_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wsu_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wsu_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			remain_q    <= '0;
			status_q    <= wsu_pkg::STAT_OK;
			wr_pend_q   <= 1'b0;
			clr_pend_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			fill_q      <= fill_d;
			remain_q    <= remain_d;
			status_q    <= status_d;
			wr_pend_q   <= wr_pend_d;
			clr_pend_q  <= clr_pend_d;
			rsp_valid_q <= emit || (rsp_valid_q && !rsp.ready);
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		word_q <= word_d;
		top_q  <= top_d;
		if (emit) begin
			popped_q   <= e_word;
			has_word_q <= e_has;
			last_q     <= e_last;
			fill_out_q <= e_fill;
			empty_q    <= (e_fill == '0);
			// top reads as zero once the stack is empty
			top_out_q  <= (e_fill == '0) ? '0 : e_top;
			stat_out_q <= e_stat;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.popped_word   = wsu_pkg::VAL_W'(popped_q);
	assign rsp.has_word      = has_word_q;
	assign rsp.last          = last_q;
	assign rsp.fill          = wsu_pkg::FILL_W'(fill_out_q);
	assign rsp.is_empty_flag = empty_q;
	assign rsp.top_word      = wsu_pkg::VAL_W'(top_out_q);
	assign rsp.status        = stat_out_q;

	// fill never goes past the stack depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(DEPTH))
		else $error("fill count above depth");

	// the single ram port pair is never written and read in one cycle
	a_ram_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("ram write and read together");

	// every popped word beat drops the fill by exactly one
	a_pop_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wsu_pkg::ST_POP_OUT && out_free) |=> fill_q == $past(fill_q) - FW'(1))
		else $error("pop did not decrement fill");

	// a beat carrying a word always has status ok
	a_word_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && has_word_q) |-> stat_out_q == wsu_pkg::STAT_OK)
		else $error("popped word with bad status");

endmodule
